FILE: hw/rtl/apsp_pkg.sv
package apsp_pkg;

  // Matrix size and derived index width
  localparam int unsigned N = 8;
  localparam int unsigned IDX_W = (N > 1) ? $clog2(N) : 1;

  // Field widths fixed by the interface
  localparam int unsigned VTX_W = 3;
  localparam int unsigned DIST_W = 14;
  localparam int unsigned FUNC_W = 2;

  localparam logic [DIST_W-1:0] INF_DIST = DIST_W'(10000);

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [VTX_W-1:0] vtx_t;

  // Control shared by all row cells
  typedef struct packed {
    logic  clear;
    logic  shift;
    logic  relax;
    idx_t  load_col;
    dist_t load_w;
    idx_t  k_pos;
    vtx_t  k_vtx;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/all_pairs_shortest_path.sv
// All-pairs shortest path engine over an 8 by 8 distance matrix.
// Input channel: func_i/row_i/col_i/weight_i with in_valid_i and in_stall_o;
// an item is taken on a clock edge with in_valid_i high and in_stall_o low.
// Clear resets every distance to 10000 and every via to 0.
// Load writes one weight (saturated to 10000; out-of-range vertices ignored).
// Run relaxes the matrix with one row cell per vertex, all rows working in
// parallel on one column per cycle. It then streams N*N = 64 items in
// row-major order on src_o/dst_o/distance_o/via_o/last_o with out_valid_o
// and out_stall_i, last_o marking the final entry. in_stall_o stays high
// until the final item has entered the output register. A stall holds the
// output item and freezes the emit sequence. Reset leaves all distances at
// 10000, vias at 0, no output.
module all_pairs_shortest_path (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [apsp_pkg::FUNC_W-1:0]  func_i,
  input  logic [apsp_pkg::VTX_W-1:0]   row_i,
  input  logic [apsp_pkg::VTX_W-1:0]   col_i,
  input  logic [apsp_pkg::DIST_W-1:0]  weight_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [apsp_pkg::VTX_W-1:0]   src_o,
  output logic [apsp_pkg::VTX_W-1:0]   dst_o,
  output logic [apsp_pkg::DIST_W-1:0]  distance_o,
  output logic [apsp_pkg::VTX_W-1:0]   via_o,
  output logic                         last_o
);
  import apsp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RELAX = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  idx_t k_q, k_d, i_q, i_d, j_q, j_d;
  logic out_valid_q, out_valid_d;
  vtx_t src_q, dst_q, via_q;
  dist_t dist_q;
  logic last_q;

  cell_ctrl_t ctrl;
  logic accept, in_range, emit_fire, j_end;
  logic [IDX_W:0] k_pos_w;
  dist_t head_dist [N];
  vtx_t head_via [N];

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_range = ({1'b0, row_i} < (VTX_W+1)'(N)) && ({1'b0, col_i} < (VTX_W+1)'(N));
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign j_end = (j_q == idx_t'(N - 1));

  // Column k sits at offset (k - j) mod N in every rotated row
  assign k_pos_w = (k_q >= j_q) ? ({1'b0, k_q} - {1'b0, j_q})
                                : ({1'b0, k_q} + (IDX_W+1)'(N) - {1'b0, j_q});

  // Shared cell control
  always_comb begin
    ctrl.clear = accept && (func_i == FUNC_CLEAR);
    ctrl.shift = (state_q == ST_RELAX) || emit_fire;
    ctrl.relax = (state_q == ST_RELAX);
    ctrl.load_col = col_i[IDX_W-1:0];
    ctrl.load_w = (weight_i > INF_DIST) ? INF_DIST : weight_i;
    ctrl.k_pos = k_pos_w[IDX_W-1:0];
    ctrl.k_vtx = VTX_W'(k_q);
  end

  // One cell per matrix row
  for (genvar r = 0; r < N; r++) begin : g_row
    apsp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_en_i   (accept && (func_i == FUNC_LOAD) && in_range &&
                    (row_i[IDX_W-1:0] == idx_t'(r))),
      .row_k_head_i(head_dist[k_q]),
      .head_dist_o (head_dist[r]),
      .head_via_o  (head_via[r])
    );
  end

  // Sequencer over k/j (relax) and i/j (emit)
  always_comb begin
    state_d = state_q;
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_RUN)) begin
          state_d = ST_RELAX;
          k_d = '0;
          j_d = '0;
        end
      end
      ST_RELAX: begin
        j_d = j_end ? '0 : j_q + idx_t'(1);
        if (j_end) begin
          if (k_q == idx_t'(N - 1)) begin
            state_d = ST_EMIT;
            i_d = '0;
          end else begin
            k_d = k_q + idx_t'(1);
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          j_d = j_end ? '0 : j_q + idx_t'(1);
          if (j_end) begin
            if (i_q == idx_t'(N - 1)) begin
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + idx_t'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      i_q <= i_d;
      j_q <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      src_q <= VTX_W'(i_q);
      dst_q <= VTX_W'(j_q);
      dist_q <= head_dist[i_q];
      via_q <= head_via[i_q];
      last_q <= j_end && (i_q == idx_t'(N - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign src_o = src_q;
  assign dst_o = dst_q;
  assign distance_o = dist_q;
  assign via_o = via_q;
  assign last_o = last_q;

endmodule

FILE: hw/rtl/apsp_cell.sv
module apsp_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apsp_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_en_i,
  input  apsp_pkg::dist_t     row_k_head_i,
  output apsp_pkg::dist_t     head_dist_o,
  output apsp_pkg::vtx_t      head_via_o
);
  import apsp_pkg::*;

  // One matrix row, rotating toward the head entry
  dist_t dist_q [N];
  vtx_t  via_q [N];

  dist_t a_ik;
  logic [DIST_W:0] sum;
  logic better;

  // Relaxation of the head entry through vertex k
  assign a_ik = dist_q[ctrl_i.k_pos];
  assign sum = {1'b0, a_ik} + {1'b0, row_k_head_i};
  assign better = ctrl_i.relax && (sum < {1'b0, dist_q[0]});

  assign head_dist_o = dist_q[0];
  assign head_via_o = via_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < N; p++) begin
        dist_q[p] <= INF_DIST;
        via_q[p] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int p = 0; p < N; p++) begin
        dist_q[p] <= INF_DIST;
        via_q[p] <= '0;
      end
    end else if (load_en_i) begin
      dist_q[ctrl_i.load_col] <= ctrl_i.load_w;
    end else if (ctrl_i.shift) begin
      for (int p = 0; p < N - 1; p++) begin
        dist_q[p] <= dist_q[p+1];
        via_q[p] <= via_q[p+1];
      end
      dist_q[N-1] <= better ? sum[DIST_W-1:0] : dist_q[0];
      via_q[N-1] <= better ? ctrl_i.k_vtx : via_q[0];
    end
  end

endmodule
